>>> sv/br90_pkg.sv
package br90_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
   localparam int ROW_W       = 6;
   localparam int COL_W       = 3;
   localparam int BYTE_W      = 8;
   localparam int HOT_W       = 6;
   localparam int ROW_BYTES   = (MAX_SIDE + 7) / 8;
   localparam int STORE_DEPTH = MAX_SIDE * ROW_BYTES;
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int BIT_W       = 3;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_HOT_X      = 2'd2,
      CSR_HOT_Y      = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_READ  = 1'b1
   } func_type;

   typedef struct packed {
      logic              func;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  byte_col;
      logic [BYTE_W-1:0] wdata;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rdata;
      logic              in_range;
      logic [HOT_W-1:0]  rot_hot_x;
      logic [HOT_W-1:0]  rot_hot_y;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

endpackage

>>> sv/bitmap_rotate_90.sv
// one-bit-per-pixel rotation store, quarter turn clockwise, LSB-first bytes
// req channel: func 0 stores a source byte at (row, byte_col); func 1 returns
// the rotated byte at destination (row, byte_col). every transaction gives
// exactly one rsp transaction carrying the byte, a range flag and the rotated
// hot spot. csr channel writes width, height and hot spot; it is always ready.
// the user must write it only while no transaction is in flight; the block
// does not enforce this. a write passes through a write state, then finish;
// a read: the shared row-address subtractor and the single memory read port
// gather one source bit per cycle, then a drain state takes in the last
// registered read, then finish. an out-of-range read skips the gather.
// throughput: one transaction at a time; req_ready is low while one is at work.
// the finished result sits in an output register, so the next req is taken
// while rsp_valid waits on a stalled receiver; a further result then holds
// until the register frees up.
// reset: control and configuration return to defaults (64 x 64, hot spot at
// the origin); the store contents are undefined until written, no clear pass.
module bitmap_rotate_90 (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  br90_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output br90_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  br90_pkg::csr_index_type csr_index,
   input  logic [br90_pkg::SIDE_W-1:0] csr_wdata
);
   import br90_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_GATHER,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [SIDE_W-1:0]  src_width_ff;
   logic [SIDE_W-1:0]  src_height_ff;
   logic [HOT_W-1:0]   hot_x_ff;
   logic [HOT_W-1:0]   hot_y_ff;

   req_type            item_ff;
   logic               ok_ff;
   logic [BIT_W-1:0]   bit_ff;
   logic               live_ff;
   logic [BYTE_W-1:0]  acc_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [SIDE_W-1:0]  eff_w;
   logic [SIDE_W-1:0]  eff_h;
   logic [SIDE_W:0]    w_round;
   logic [SIDE_W:0]    h_round;
   logic               wr_ok;
   logic               rd_ok;
   logic               req_fire;
   logic               out_free;
   logic [ROW_W-1:0]   dx;
   logic               dx_live;
   logic [SIDE_W-1:0]  sy_full;
   logic [SIDE_W-1:0]  hot_full;
   store_wr_type       store_wr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;

   assign eff_w = (src_width_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : src_width_ff;
   assign eff_h = (src_height_ff > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : src_height_ff;
   assign w_round = {1'b0, eff_w} + (SIDE_W+1)'(7);
   assign h_round = {1'b0, eff_h} + (SIDE_W+1)'(7);

   // writes check against the source size, reads against the rotated size
   assign wr_ok = ({1'b0, req_data.row} < eff_h) &&
                  ({1'b0, req_data.byte_col} < w_round[SIDE_W:3]);
   assign rd_ok = ({1'b0, req_data.row} < eff_w) &&
                  ({1'b0, req_data.byte_col} < h_round[SIDE_W:3]);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // shared subtractor: destination x maps to source row h-1-x
   assign dx      = {item_ff.byte_col, bit_ff};
   assign dx_live = ({1'b0, dx} < eff_h);
   assign sy_full = eff_h - SIDE_W'(1) - {1'b0, dx};
   assign rd_en   = (state_ff == ST_GATHER);
   assign rd_addr = {sy_full[ROW_W-1:0], item_ff.row[ROW_W-1:BIT_W]};

   assign hot_full = eff_h - {1'b0, hot_y_ff} - SIDE_W'(1);

   always_comb begin
      store_wr.en   = (state_ff == ST_WRITE) && ok_ff;
      store_wr.addr = {item_ff.row, item_ff.byte_col};
      store_wr.data = item_ff.wdata;
   end

   br90_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SIDE_W'(MAX_SIDE);
         src_height_ff <= SIDE_W'(MAX_SIDE);
         hot_x_ff      <= '0;
         hot_y_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_HOT_X:      hot_x_ff      <= csr_wdata[HOT_W-1:0];
            CSR_HOT_Y:      hot_y_ff      <= csr_wdata[HOT_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_ff       <= '0;
         live_ff      <= 1'b0;
      end else begin
         priority if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // capture the bit fetched in the previous cycle
         if (state_ff == ST_GATHER || state_ff == ST_DRAIN) begin
            if (live_ff) begin
               acc_ff <= {rd_data[item_ff.row[BIT_W-1:0]], acc_ff[BYTE_W-1:1]};
            end else begin
               acc_ff <= {1'b0, acc_ff[BYTE_W-1:1]};
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  item_ff <= req_data;
                  bit_ff  <= '0;
                  live_ff <= 1'b0;
                  acc_ff  <= '0;
                  if (req_data.func == FUNC_WRITE) begin
                     ok_ff    <= wr_ok;
                     state_ff <= ST_WRITE;
                  end else begin
                     ok_ff    <= rd_ok;
                     state_ff <= rd_ok ? ST_GATHER : ST_FINISH;
                  end
               end
            end
            ST_WRITE: begin
               state_ff <= ST_FINISH;
            end
            ST_GATHER: begin
               live_ff <= dx_live;
               bit_ff  <= bit_ff + BIT_W'(1);
               if (bit_ff == BIT_W'(BYTE_W - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_ff.rdata     <= (item_ff.func == FUNC_READ && ok_ff) ? acc_ff : '0;
                  rsp_ff.in_range  <= ok_ff;
                  rsp_ff.rot_hot_x <= hot_full[HOT_W-1:0];
                  rsp_ff.rot_hot_y <= hot_x_ff;
                  state_ff         <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/br90_store.sv
module br90_store (
   input  logic                  clock,
   input  br90_pkg::store_wr_type wr,
   input  logic                  rd_en,
   input  logic [br90_pkg::ADDR_W-1:0] rd_addr,
   output logic [br90_pkg::BYTE_W-1:0] rd_data
);
   import br90_pkg::*;

   logic [BYTE_W-1:0] mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // address is {row, byte column}
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/bitmap_rotate_90_tb.sv
module bitmap_rotate_90_tb;
   import br90_pkg::*;

   localparam int HOLD_OFF     = 400;
   localparam int SETTLE       = 16;
   localparam int LIMIT_CYCLES = 1000000;

   class rotate_scoreboard;
      logic [BYTE_W-1:0] source_bytes [STORE_DEPTH];
      int unsigned side_w;
      int unsigned side_h;
      logic [HOT_W-1:0] hot_x;
      logic [HOT_W-1:0] hot_y;
      rsp_type rotated_rsp_q [$];
      int mismatches;

      function new();
         side_w = MAX_SIDE;
         side_h = MAX_SIDE;
         hot_x = '0;
         hot_y = '0;
         mismatches = 0;
         foreach (source_bytes[i]) source_bytes[i] = '0;
      endfunction

      function void set_reg(csr_index_type idx, logic [SIDE_W-1:0] v);
         unique case (idx)
            CSR_SRC_WIDTH:  side_w = v;
            CSR_SRC_HEIGHT: side_h = v;
            CSR_HOT_X:      hot_x = v[HOT_W-1:0];
            CSR_HOT_Y:      hot_y = v[HOT_W-1:0];
            default: ;
         endcase
      endfunction

      // works out the rotated byte (or the store update) for one transaction
      function void note_req(req_type r);
         int w;
         int h;
         int dx;
         rsp_type exp_rsp;
         w = (side_w > MAX_SIDE) ? MAX_SIDE : side_w;
         h = (side_h > MAX_SIDE) ? MAX_SIDE : side_h;
         exp_rsp = '0;
         if (r.func == FUNC_WRITE) begin
            if (r.row < h && r.byte_col < (w + 7) / 8) begin
               source_bytes[r.row * ROW_BYTES + r.byte_col] = r.wdata;
               exp_rsp.in_range = 1'b1;
            end
         end else if (r.row < w && r.byte_col < (h + 7) / 8) begin
            exp_rsp.in_range = 1'b1;
            for (int b = 0; b < BYTE_W; b++) begin
               dx = r.byte_col * 8 + b;
               // destination x maps back to source row h-1-x, padding stays zero
               if (dx < h)
                  exp_rsp.rdata[b] =
                     source_bytes[(h - 1 - dx) * ROW_BYTES + r.row[5:3]][r.row[2:0]];
            end
         end
         exp_rsp.rot_hot_x = HOT_W'(h - int'(hot_y) - 1);
         exp_rsp.rot_hot_y = hot_x;
         rotated_rsp_q.push_back(exp_rsp);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type exp_rsp;
         if (rotated_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp transaction: rdata %02h in_range %0d hot %0d,%0d",
                        got.rdata, got.in_range, got.rot_hot_x, got.rot_hot_y);
            return;
         end
         exp_rsp = rotated_rsp_q.pop_front();
         if (got.rdata !== exp_rsp.rdata || got.in_range !== exp_rsp.in_range ||
             got.rot_hot_x !== exp_rsp.rot_hot_x || got.rot_hot_y !== exp_rsp.rot_hot_y) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %02h %0d hot %0d,%0d; got %02h %0d hot %0d,%0d",
                        exp_rsp.rdata, exp_rsp.in_range, exp_rsp.rot_hot_x,
                        exp_rsp.rot_hot_y, got.rdata, got.in_range, got.rot_hot_x,
                        got.rot_hot_y);
         end
      endfunction

      function int pending();
         return rotated_rsp_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [SIDE_W-1:0] csr_wdata;

   rotate_scoreboard rot_board;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off_pending;
   int cur_w;
   int cur_h;

   bitmap_rotate_90 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) rot_board.check_rsp(rsp_data);
         if (req_valid && req_ready) rot_board.note_req(req_data);
         if (csr_valid && csr_ready) rot_board.set_reg(csr_index, csr_wdata);
      end
   end

   // receiver: random back-pressure, plus a long hold-off when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            repeat (HOLD_OFF) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #(4 * LIMIT_CYCLES);
      $display("bitmap_rotate_90_tb: FAIL");
      $finish;
   end

   task automatic send_item(func_type f, int r, int c, int d);
      req_type item;
      item.func = f;
      item.row = r[ROW_W-1:0];
      item.byte_col = c[COL_W-1:0];
      item.wdata = d[BYTE_W-1:0];
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for every outstanding transaction to come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rot_board.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [SIDE_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_geometry(int w, int h, int hx, int hy);
      write_reg(CSR_SRC_WIDTH, w[SIDE_W-1:0]);
      write_reg(CSR_SRC_HEIGHT, h[SIDE_W-1:0]);
      write_reg(CSR_HOT_X, hx[SIDE_W-1:0]);
      write_reg(CSR_HOT_Y, hy[SIDE_W-1:0]);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_w = (w > MAX_SIDE) ? MAX_SIDE : w;
      cur_h = (h > MAX_SIDE) ? MAX_SIDE : h;
   endtask

   function automatic int pick_side();
      unique case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return MAX_SIDE;
         3: return $urandom_range(MAX_SIDE + 1, 127);
         default: return $urandom_range(1, MAX_SIDE);
      endcase
   endfunction

   task automatic send_random();
      func_type f;
      int lim_r;
      int lim_c;
      int r;
      int c;
      f = $urandom_range(1) ? FUNC_READ : FUNC_WRITE;
      lim_r = (f == FUNC_READ) ? cur_w : cur_h;
      lim_c = (f == FUNC_READ) ? (cur_h + 7) / 8 : (cur_w + 7) / 8;
      if (lim_r > 0 && lim_c > 0 && $urandom_range(99) < 85) begin
         r = $urandom_range(lim_r - 1);
         c = $urandom_range(lim_c - 1);
      end else begin
         r = $urandom_range(63);
         c = $urandom_range(7);
      end
      send_item(f, r, c, $urandom_range(255));
   endtask

   initial begin
      rot_board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SRC_WIDTH;
      csr_wdata = '0;
      hold_off_pending = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 56;
      cur_w = MAX_SIDE;
      cur_h = MAX_SIDE;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load the whole store so no read ever gathers an unwritten byte
      for (int r = 0; r < MAX_SIDE; r++)
         for (int c = 0; c < ROW_BYTES; c++)
            send_item(FUNC_WRITE, r, c, $urandom_range(255));

      send_item(FUNC_WRITE, 0, 0, 8'hff);
      send_item(FUNC_WRITE, 63, 7, 8'h00);
      send_item(FUNC_WRITE, 63, 0, 8'h80);
      send_item(FUNC_READ, 0, 0, 8'h00);
      send_item(FUNC_READ, 63, 7, 8'hff);
      send_item(FUNC_READ, 7, 7, 8'h00);
      settle();
      // small bitmap, hot spot outside it so rot_hot_x wraps
      write_geometry(9, 5, 63, 10);
      send_item(FUNC_WRITE, 4, 1, 8'haa);
      send_item(FUNC_WRITE, 5, 0, 8'h55);
      send_item(FUNC_WRITE, 0, 2, 8'h0f);
      send_item(FUNC_READ, 8, 0, 8'h00);
      send_item(FUNC_READ, 9, 0, 8'h00);
      send_item(FUNC_READ, 0, 1, 8'h00);
      settle();
      write_geometry(0, 127, 0, 127);
      send_item(FUNC_WRITE, 0, 0, 8'h3c);
      send_item(FUNC_READ, 0, 0, 8'h00);
      settle();
      write_geometry(127, 0, 0, 0);
      send_item(FUNC_READ, 0, 0, 8'h00);
      send_item(FUNC_WRITE, 0, 0, 8'hc3);
      settle();
      write_geometry(127, 127, 127, 0);
      send_item(FUNC_READ, 63, 7, 8'h00);
      send_item(FUNC_WRITE, 63, 7, 8'hff);
      send_item(FUNC_READ, 0, 7, 8'h00);
      send_item(FUNC_READ, 63, 0, 8'h00);
      settle();
      write_geometry(1, 1, 0, 0);
      send_item(FUNC_READ, 0, 0, 8'h00);
      send_item(FUNC_WRITE, 0, 0, 8'hfe);
      send_item(FUNC_READ, 0, 0, 8'h00);
      send_item(FUNC_READ, 1, 0, 8'h00);

      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 11; recv_idle_pct = 56; end
            1: begin send_idle_pct = 56; recv_idle_pct = 11; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 7; seg++) begin
            settle();
            write_geometry(pick_side(), pick_side(), $urandom_range(127), $urandom_range(127));
            // block fills while the receiver sits idle
            if (seg == 1 && phase != 1) hold_off_pending = 1'b1;
            repeat ($urandom_range(35, 70)) send_random();
         end
      end

      settle();
      if (rot_board.pending() != 0)
         $display("%0d expected rsp transactions never arrived", rot_board.pending());
      if (rot_board.mismatches == 0 && rot_board.pending() == 0)
         $display("bitmap_rotate_90_tb: PASS");
      else
         $display("bitmap_rotate_90_tb: FAIL");
      $finish;
   end

endmodule
